// ----- design/assert_macros.svh -----
// Assertion macros used by the frame receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/slfr_pkg.sv -----
// Types and constants of the sync-byte length-prefixed frame receiver.
package slfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  // Item kinds on the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic REG_SYNC_VALUE = 1'b0;
  localparam logic REG_IDLE_LIMIT = 1'b1;

  localparam logic [7:0]  SYNC_RESET       = 8'hA5;
  localparam logic [19:0] IDLE_LIMIT_RESET = 20'd40000;
  localparam logic [19:0] IDLE_MAX         = 20'hFFFFF;

  // Header layout: sync byte, one spare byte, length low, length high
  localparam logic [16:0] HEADER_BYTES = 17'd4;
  localparam logic [16:0] LEN_LOW_POS  = 17'd2;
  localparam logic [16:0] LEN_HIGH_POS = 17'd3;

endpackage

// ----- design/sync_length_frame_receiver.sv -----
// Top level of the sync-byte length-prefixed frame receiver.
//
// Frame receiver for a byte stream: each input transfer carries either a received byte
// or one time tick, and each produces exactly one result transfer. A frame opens with a
// byte equal to sync_value; bytes 2 and 3 give the little-endian payload length, and the
// frame closes after that many bytes beyond the four-byte header (a zero length closes
// it at the fourth byte). Every byte is echoed with its position in the frame; the
// closing byte also carries frame_done and the total frame length. A wrong first byte
// is echoed with sync_reject and the search goes on. Ticks count idle time after the
// last byte of a partial frame; reaching idle_limit reports timeout_abort and drops the
// frame. The frame state updates and the result register loads on the same edge that
// accepts the item, so with out_ready held high one item is taken every cycle, and a
// waiting result does not block the next transfer once out_ready takes it. Write
// configuration only while no result is outstanding.
module sync_length_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [19:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  byte_out,
  output logic [16:0] byte_position,
  output logic        frame_done,
  output logic [16:0] frame_length,
  output logic        sync_reject,
  output logic        timeout_abort
);

  import slfr_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  logic [7:0]  sync_value;
  logic [19:0] idle_limit;

  // Frame state
  phase_t      phase, phase_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] payload_length, payload_length_next;
  logic        awaiting_bytes, awaiting_bytes_next;
  logic [19:0] idle_ticks, idle_ticks_next;

  // Result fields computed for the transfer being accepted
  logic        res_byte_valid;
  logic [16:0] res_frame_length;
  logic        res_frame_done;
  logic        res_sync_reject;
  logic        res_timeout;

  logic        in_fire;
  logic        clear_frame;
  logic [16:0] count_inc;
  logic [16:0] frame_end;
  logic [19:0] idle_inc;

  // Accept whenever the result register is empty or is being emptied this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign count_inc = byte_count + 17'd1;
  assign frame_end = {1'b0, payload_length} + HEADER_BYTES;
  // Saturate the idle count at its maximum.
  assign idle_inc  = (idle_ticks != IDLE_MAX) ? idle_ticks + 20'd1 : idle_ticks;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_SYNC_VALUE: sync_value <= cfg_data[7:0];
        REG_IDLE_LIMIT: idle_limit <= cfg_data;
        default:        sync_value <= sync_value;
      endcase
    end
  end

  // Next frame state and the result of the accepted transfer
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    length_low_next     = length_low;
    payload_length_next = payload_length;
    awaiting_bytes_next = awaiting_bytes;
    idle_ticks_next     = idle_ticks;
    res_byte_valid      = 1'b0;
    res_frame_done      = 1'b0;
    res_frame_length    = '0;
    res_sync_reject     = 1'b0;
    res_timeout         = 1'b0;
    clear_frame         = 1'b0;

    if (in_fire) begin
      if (opcode == OP_TICK) begin
        // Count idle time only while a frame is partial.
        if (awaiting_bytes) begin
          idle_ticks_next = idle_inc;
          if (idle_inc >= idle_limit) begin
            res_timeout = 1'b1;
            clear_frame = 1'b1;
          end
        end
      end else begin
        res_byte_valid      = 1'b1;
        idle_ticks_next     = '0;
        awaiting_bytes_next = 1'b1;
        byte_count_next     = count_inc;
        unique case (phase)
          PH_HUNT: begin
            if (data_byte != sync_value) begin
              res_sync_reject = 1'b1;
              clear_frame     = 1'b1;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_HEADER: begin
            if (byte_count == LEN_LOW_POS) begin
              length_low_next = data_byte;
            end else if (byte_count == LEN_HIGH_POS) begin
              payload_length_next = {data_byte, length_low};
              phase_next          = PH_PAYLOAD;
              // Empty payload: the header byte closes the frame.
              if ({data_byte, length_low} == 16'd0) begin
                res_frame_done   = 1'b1;
                res_frame_length = HEADER_BYTES;
                clear_frame      = 1'b1;
              end
            end
          end
          default: begin
            if (count_inc >= frame_end) begin
              res_frame_done   = 1'b1;
              res_frame_length = count_inc;
              clear_frame      = 1'b1;
            end
          end
        endcase
      end
    end

    // Drop every piece of frame state on completion, rejection or abort.
    if (clear_frame) begin
      phase_next          = PH_HUNT;
      byte_count_next     = '0;
      length_low_next     = '0;
      payload_length_next = '0;
      awaiting_bytes_next = 1'b0;
      idle_ticks_next     = '0;
    end
  end

  // Frame state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= '0;
      length_low     <= '0;
      payload_length <= '0;
      awaiting_bytes <= 1'b0;
      idle_ticks     <= '0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      length_low     <= length_low_next;
      payload_length <= payload_length_next;
      awaiting_bytes <= awaiting_bytes_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

  // Result register: valid flag under reset, payload loads on each accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_valid    <= res_byte_valid;
      byte_out      <= res_byte_valid ? data_byte : 8'd0;
      byte_position <= res_byte_valid ? byte_count : 17'd0;
      frame_done    <= res_frame_done;
      frame_length  <= res_frame_length;
      sync_reject   <= res_sync_reject;
      timeout_abort <= res_timeout;
    end
  end

  // Hunting always starts from a zero count, and a partial frame is always awaiting bytes.
  `ASSERT_SAME_CYCLE(a_hunt_count_zero, clk, rst, phase == PH_HUNT, byte_count == 17'd0)
  `ASSERT_SAME_CYCLE(a_partial_awaits, clk, rst, phase != PH_HUNT, awaiting_bytes)
  // A result reports at most one frame event, and a timeout never echoes a byte.
  `ASSERT_SAME_CYCLE(a_one_event, clk, rst, out_valid,
                     $countones({frame_done, sync_reject, timeout_abort}) <= 1)
  `ASSERT_SAME_CYCLE(a_timeout_no_byte, clk, rst, out_valid && timeout_abort, !byte_valid)
  // The closing byte sits at the last position of the frame.
  `ASSERT_SAME_CYCLE(a_done_length, clk, rst, out_valid && frame_done,
                     frame_length == byte_position + 17'd1)
  // An abort leaves the receiver hunting with nothing pending.
  `ASSERT_NEXT_CYCLE(a_abort_clears, clk, rst, in_fire && res_timeout,
                     phase == PH_HUNT && !awaiting_bytes)

endmodule
